### hw/rtl/htb_pkg.sv
// ----------------------------------------------------------------------------
// htb_pkg
// shared widths, codes and types of the huffman tree builder
// ----------------------------------------------------------------------------
package htb_pkg;

    // fixed field widths of the channels
    localparam int LEAF_W       = 16;
    localparam int NODE_IDX_W   = 6;
    localparam int LINK_W       = 7;
    localparam int OUT_WEIGHT_W = 21;

    // defaults for the top level parameters
    localparam int DEF_MAX_LEAVES  = 32;
    localparam int DEF_WEIGHT_BITS = 16;

    typedef logic [LINK_W-1:0] t_link;

    // link code for "no node"
    localparam t_link LINK_NONE = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LINK,
        S_PAR_A,
        S_PAR_B,
        S_OUT_RD,
        S_OUT_LOAD,
        S_OUT_HOLD
    } t_state;

    // control of the shared min-search unit
    typedef struct packed {
        logic clear;
        logic eval;
        logic use_skip;
    } t_scan_ctl;

endpackage

### hw/rtl/htb_leaf_if.sv
// ----------------------------------------------------------------------------
// htb_leaf_if
// leaf weight channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface htb_leaf_if import htb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LEAF_W-1:0] leaf_weight;
    logic              last_leaf;

    modport source (output valid, output leaf_weight, output last_leaf, input ready);
    modport sink   (input valid, input leaf_weight, input last_leaf, output ready);
endinterface

### hw/rtl/htb_node_if.sv
// ----------------------------------------------------------------------------
// htb_node_if
// node record channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface htb_node_if import htb_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [NODE_IDX_W-1:0]   node_index;
    logic [LINK_W-1:0]       left_child;
    logic [OUT_WEIGHT_W-1:0] node_weight;
    logic [LINK_W-1:0]       right_child;
    logic [LINK_W-1:0]       parent_index;
    logic                    last_node;

    modport source (
        output valid, output node_index, output left_child, output node_weight,
        output right_child, output parent_index, output last_node, input ready
    );
    modport sink (
        input valid, input node_index, input left_child, input node_weight,
        input right_child, input parent_index, input last_node, output ready
    );
endinterface

### hw/rtl/htb_ram.sv
// ----------------------------------------------------------------------------
// htb_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module htb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/htb_min_unit.sv
// ----------------------------------------------------------------------------
// htb_min_unit
// shared compare unit: tracks the lightest parentless node of one scan
// ----------------------------------------------------------------------------
module htb_min_unit import htb_pkg::*; #(
    parameter int IDX_W = 6,
    parameter int SUM_W = 21
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_scan_ctl        i_ctl,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [IDX_W-1:0] i_skip,
    input  logic [SUM_W-1:0] i_weight,
    input  t_link            i_parent,
    output logic [IDX_W-1:0] o_best_idx,
    output logic [SUM_W-1:0] o_best_weight
);

    logic             r_found;
    logic [IDX_W-1:0] r_best_idx;
    logic [SUM_W-1:0] r_best_w;
    logic             take;

    // strict less-than keeps the lowest index on ties
    always_comb begin
        take = i_ctl.eval && (i_parent == LINK_NONE)
            && !(i_ctl.use_skip && (i_idx == i_skip))
            && (!r_found || (i_weight < r_best_w));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !i_ctl.clear) begin
            r_best_idx <= i_idx;
            r_best_w   <= i_weight;
        end
    end

    assign o_best_idx    = r_best_idx;
    assign o_best_weight = r_best_w;

endmodule

### hw/rtl/huffman_tree_builder_unit.sv
// ----------------------------------------------------------------------------
// huffman_tree_builder_unit
// builds a huffman tree from leaf weights and reports every node record
// ----------------------------------------------------------------------------
// usage:
//   i_leaf takes one leaf weight per word; last_leaf marks the final leaf of a
//   run, and a leaf that fills the store to MAX_LEAVES ends the run as well.
//   a leaf that is not last gives nothing back.
//   after the last leaf of n the block builds n-1 internal nodes, then sends
//   2n-1 node records on o_node in index order, last_node set on the final one.
//   internal node i takes two scans over nodes 0..i-1 through one shared
//   compare unit fed by the node rams, then writes the new node and the
//   parent links of both children. each record then goes through ram read,
//   load and send; the next record is read once this one is taken.
//   i_leaf.ready is high only while idle, not while building or sending.
//   a stalled receiver just holds the record in the output register; the
//   build is done by then, but the next run's leaves wait for the last record.
//   reset returns to idle with no leaves held; the rams need no clearing
//   since every entry is written before it is read in a run.
// ----------------------------------------------------------------------------
module huffman_tree_builder_unit import htb_pkg::*; #(
    parameter int MAX_LEAVES  = DEF_MAX_LEAVES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    htb_leaf_if.sink   i_leaf,
    htb_node_if.source o_node
);

    localparam int NODE_CAP = 2 * MAX_LEAVES - 1;
    localparam int IDX_W    = (NODE_CAP > 1) ? $clog2(NODE_CAP) : 1;
    localparam int CNT_W    = $clog2(NODE_CAP + 1);
    localparam int KEEP_W   = (WEIGHT_BITS < LEAF_W) ? WEIGHT_BITS : LEAF_W;
    // a sum over all leaves stays below MAX_LEAVES * 2^WEIGHT_BITS
    localparam int SUM_W    = WEIGHT_BITS + $clog2(MAX_LEAVES);

    // sequencer state
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;        // leaves held
    logic [CNT_W-1:0] r_total, n_total;    // nodes in this run
    logic [CNT_W-1:0] r_node, n_node;      // node being built
    logic [CNT_W-1:0] r_j, n_j;            // scan read pointer
    logic [CNT_W-1:0] r_k, n_k;            // output pointer
    logic             r_pend, n_pend;      // read data of last scan address is due
    logic [IDX_W-1:0] r_pend_idx, n_pend_idx;
    logic             r_pass, n_pass;      // 0: left pick, 1: right pick
    logic [IDX_W-1:0] r_a, n_a;
    logic [SUM_W-1:0] r_wa, n_wa;
    logic [IDX_W-1:0] r_b, n_b;

    // output word register
    logic                    r_out_valid, n_out_valid;
    logic [NODE_IDX_W-1:0]   r_out_idx;
    t_link                   r_out_left;
    logic [OUT_WEIGHT_W-1:0] r_out_weight;
    t_link                   r_out_right;
    t_link                   r_out_parent;
    logic                    r_out_last;
    logic                    out_load;

    // ram ports
    logic              w_we, p_we, l_we;
    logic [IDX_W-1:0]  w_waddr, p_waddr, l_waddr;
    logic [SUM_W-1:0]  w_wdata;
    t_link             p_wdata;
    logic [2*LINK_W-1:0] l_wdata;
    logic [IDX_W-1:0]  rd_addr;
    logic [SUM_W-1:0]  w_rdata;
    t_link             p_rdata;
    logic [2*LINK_W-1:0] l_rdata;

    // min unit
    t_scan_ctl        scan_ctl;
    logic [IDX_W-1:0] best_idx;
    logic [SUM_W-1:0] best_w;

    logic             leaf_acc;
    logic             leaf_end;
    logic [CNT_W-1:0] n_leaves;
    logic [SUM_W-1:0] leaf_w;
    logic             issue;
    logic             scan_done;

    assign leaf_acc  = i_leaf.valid && i_leaf.ready;
    assign n_leaves  = r_cnt + CNT_W'(1);
    // the leaf that fills the store closes the run
    assign leaf_end  = i_leaf.last_leaf || (n_leaves == CNT_W'(MAX_LEAVES));
    assign leaf_w    = SUM_W'(i_leaf.leaf_weight[KEEP_W-1:0]);
    assign issue     = (r_state == S_SCAN) && (r_j != r_node);
    assign scan_done = (r_state == S_SCAN) && (r_j == r_node) && !r_pend;

    assign i_leaf.ready = (r_state == S_IDLE);

    htb_ram #(.WIDTH(SUM_W), .DEPTH(NODE_CAP)) u_weight_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_we),
        .i_wr_addr (w_waddr),
        .i_wr_data (w_wdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (w_rdata)
    );

    htb_ram #(.WIDTH(LINK_W), .DEPTH(NODE_CAP)) u_parent_ram (
        .i_clk     (i_clk),
        .i_wr_en   (p_we),
        .i_wr_addr (p_waddr),
        .i_wr_data (p_wdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (p_rdata)
    );

    // left and right child links share one word
    htb_ram #(.WIDTH(2*LINK_W), .DEPTH(NODE_CAP)) u_child_ram (
        .i_clk     (i_clk),
        .i_wr_en   (l_we),
        .i_wr_addr (l_waddr),
        .i_wr_data (l_wdata),
        .i_rd_addr (rd_addr),
        .o_rd_data (l_rdata)
    );

    htb_min_unit #(.IDX_W(IDX_W), .SUM_W(SUM_W)) u_min (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (scan_ctl),
        .i_idx         (r_pend_idx),
        .i_skip        (r_a),
        .i_weight      (w_rdata),
        .i_parent      (p_rdata),
        .o_best_idx    (best_idx),
        .o_best_weight (best_w)
    );

    // next state and ram control
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_node      = r_node;
        n_j         = r_j;
        n_k         = r_k;
        n_pend      = 1'b0;
        n_pend_idx  = r_j[IDX_W-1:0];
        n_pass      = r_pass;
        n_a         = r_a;
        n_wa        = r_wa;
        n_b         = r_b;
        n_out_valid = r_out_valid;
        out_load    = 1'b0;

        w_we    = 1'b0;
        p_we    = 1'b0;
        l_we    = 1'b0;
        w_waddr = r_node[IDX_W-1:0];
        p_waddr = r_node[IDX_W-1:0];
        l_waddr = r_node[IDX_W-1:0];
        w_wdata = r_wa + best_w;
        p_wdata = LINK_NONE;
        l_wdata = {LINK_W'(r_a), LINK_W'(best_idx)};
        rd_addr = r_j[IDX_W-1:0];

        scan_ctl.clear    = (r_state == S_SCAN) && (r_j == '0) && !r_pend;
        scan_ctl.eval     = r_pend;
        scan_ctl.use_skip = r_pass;

        case (r_state)
            S_IDLE: begin
                if (leaf_acc) begin
                    // store the leaf with no parent and no children
                    w_we    = 1'b1;
                    p_we    = 1'b1;
                    l_we    = 1'b1;
                    w_waddr = r_cnt[IDX_W-1:0];
                    p_waddr = r_cnt[IDX_W-1:0];
                    l_waddr = r_cnt[IDX_W-1:0];
                    w_wdata = leaf_w;
                    p_wdata = LINK_NONE;
                    l_wdata = {LINK_NONE, LINK_NONE};
                    if (leaf_end) begin
                        n_cnt   = '0;
                        n_total = CNT_W'((n_leaves << 1) - CNT_W'(1));
                        n_node  = n_leaves;
                        n_j     = '0;
                        n_k     = '0;
                        n_pass  = 1'b0;
                        // a lone leaf has nothing to join
                        if (n_leaves == CNT_W'(1)) begin
                            n_state = S_OUT_RD;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_cnt = n_leaves;
                    end
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_j        = r_j + CNT_W'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_j[IDX_W-1:0];
                end
                if (scan_done) begin
                    n_j = '0;
                    if (!r_pass) begin
                        n_a     = best_idx;
                        n_wa    = best_w;
                        n_pass  = 1'b1;
                    end else begin
                        n_b     = best_idx;
                        n_state = S_LINK;
                    end
                end
            end
            S_LINK: begin
                // new node: summed weight, both children, no parent yet
                w_we    = 1'b1;
                l_we    = 1'b1;
                p_we    = 1'b1;
                w_wdata = r_wa + best_w;
                l_wdata = {LINK_W'(r_a), LINK_W'(r_b)};
                p_wdata = LINK_NONE;
                n_state = S_PAR_A;
            end
            S_PAR_A: begin
                p_we    = 1'b1;
                p_waddr = r_a;
                p_wdata = LINK_W'(r_node);
                n_state = S_PAR_B;
            end
            S_PAR_B: begin
                p_we    = 1'b1;
                p_waddr = r_b;
                p_wdata = LINK_W'(r_node);
                n_j     = '0;
                n_pass  = 1'b0;
                if ((r_node + CNT_W'(1)) == r_total) begin
                    n_k     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_node  = r_node + CNT_W'(1);
                    n_state = S_SCAN;
                end
            end
            S_OUT_RD: begin
                rd_addr = r_k[IDX_W-1:0];
                n_state = S_OUT_LOAD;
            end
            S_OUT_LOAD: begin
                out_load    = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (o_node.ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + CNT_W'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers, written before use in every run
    always_ff @(posedge i_clk) begin
        r_total    <= n_total;
        r_node     <= n_node;
        r_j        <= n_j;
        r_k        <= n_k;
        r_pend_idx <= n_pend_idx;
        r_a        <= n_a;
        r_wa       <= n_wa;
        r_b        <= n_b;
    end

    // output word, loaded from the registered ram read data in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_idx    <= NODE_IDX_W'(r_k);
            r_out_left   <= l_rdata[2*LINK_W-1:LINK_W];
            r_out_right  <= l_rdata[LINK_W-1:0];
            r_out_weight <= OUT_WEIGHT_W'(w_rdata);
            r_out_parent <= p_rdata;
            r_out_last   <= ((r_k + CNT_W'(1)) == r_total);
        end
    end

    assign o_node.valid        = r_out_valid;
    assign o_node.node_index   = r_out_idx;
    assign o_node.left_child   = r_out_left;
    assign o_node.node_weight  = r_out_weight;
    assign o_node.right_child  = r_out_right;
    assign o_node.parent_index = r_out_parent;
    assign o_node.last_node    = r_out_last;

endmodule

### tb/huffman_tree_builder_unit_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_tree_builder_unit_chk
// watches both channels, grows its own tree per run and checks every record
// ----------------------------------------------------------------------------
module huffman_tree_builder_unit_chk import htb_pkg::*; #(
    parameter int MAX_LEAVES  = DEF_MAX_LEAVES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    htb_leaf_if  i_leaf,
    htb_node_if  i_node,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_records,
    output int   o_trees,
    output int   o_full_trees
);

    localparam int              NODE_CAP    = 2 * MAX_LEAVES - 1;
    localparam int              NO_NODE     = -1;
    localparam longint unsigned WEIGHT_MASK = (64'd1 << WEIGHT_BITS) - 64'd1;

    typedef struct {
        logic [NODE_IDX_W-1:0]   idx;
        t_link                   left;
        logic [OUT_WEIGHT_W-1:0] weight;
        t_link                   right;
        t_link                   parent;
        logic                    last;
    } t_node_rec;

    longint unsigned tree_weight [NODE_CAP];
    int              tree_parent [NODE_CAP];
    int              tree_left   [NODE_CAP];
    int              tree_right  [NODE_CAP];
    int              leaves_held = 0;

    t_node_rec expected_nodes[$];

    int fails      = 0;
    int records    = 0;
    int trees      = 0;
    int full_trees = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fails++;
    endtask

    task automatic check_field(input string field, input int node, input longint got,
                               input longint want);
        if (got != want)
            report_mismatch($sformatf("node %0d %s got 0x%0h expected 0x%0h",
                                      node, field, got, want));
    endtask

    // lightest node without a parent below limit, skip excluded, lowest index on ties
    function automatic int lightest_orphan(input int limit, input int skip);
        int best;
        best = NO_NODE;
        for (int j = 0; j < limit; j++) begin
            if (tree_parent[j] == NO_NODE && j != skip)
                if (best == NO_NODE || tree_weight[j] < tree_weight[best])
                    best = j;
        end
        return best;
    endfunction

    task automatic add_leaf(input logic [LEAF_W-1:0] w, input logic is_last);
        int        n;
        int        a;
        int        b;
        t_node_rec rec;
        if (leaves_held >= MAX_LEAVES)
            leaves_held = 0;
        tree_weight[leaves_held] = longint'(w) & WEIGHT_MASK;
        tree_parent[leaves_held] = NO_NODE;
        tree_left[leaves_held]   = NO_NODE;
        tree_right[leaves_held]  = NO_NODE;
        leaves_held++;
        if (!is_last && leaves_held < MAX_LEAVES)
            return;

        n = leaves_held;
        for (int i = n; i < 2 * n - 1; i++) begin
            a = lightest_orphan(i, NO_NODE);
            b = lightest_orphan(i, a);
            if (a == NO_NODE || b == NO_NODE)
                break;
            tree_weight[i] = tree_weight[a] + tree_weight[b];
            tree_parent[i] = NO_NODE;
            tree_left[i]   = a;
            tree_right[i]  = b;
            tree_parent[a] = i;
            tree_parent[b] = i;
        end

        for (int i = 0; i < 2 * n - 1; i++) begin
            rec.idx    = NODE_IDX_W'(i);
            rec.left   = t_link'(tree_left[i]);
            rec.weight = OUT_WEIGHT_W'(tree_weight[i]);
            rec.right  = t_link'(tree_right[i]);
            rec.parent = t_link'(tree_parent[i]);
            rec.last   = (i == 2 * n - 2);
            expected_nodes.push_back(rec);
        end
        if (n == MAX_LEAVES)
            full_trees++;
        trees++;
        leaves_held = 0;
    endtask

    task automatic check_node();
        t_node_rec want;
        if (expected_nodes.size() == 0) begin
            report_mismatch($sformatf("node record %0d with nothing expected",
                                      i_node.node_index));
            return;
        end
        want = expected_nodes.pop_front();
        records++;
        check_field("node_index",   want.idx, i_node.node_index,   want.idx);
        check_field("left_child",   want.idx, i_node.left_child,   want.left);
        check_field("node_weight",  want.idx, i_node.node_weight,  want.weight);
        check_field("right_child",  want.idx, i_node.right_child,  want.right);
        check_field("parent_index", want.idx, i_node.parent_index, want.parent);
        check_field("last_node",    want.idx, i_node.last_node,    want.last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_nodes.delete();
            leaves_held = 0;
        end else begin
            if (i_node.valid && i_node.ready)
                check_node();
            if (i_leaf.valid && i_leaf.ready)
                add_leaf(i_leaf.leaf_weight, i_leaf.last_leaf);
        end
        o_pending    <= expected_nodes.size();
        o_fail_count <= fails;
        o_records    <= records;
        o_trees      <= trees;
        o_full_trees <= full_trees;
    end

endmodule

### tb/huffman_tree_builder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_tree_builder_unit_tb
// leaf runs of many sizes and weight shapes with random stalls on both sides
// ----------------------------------------------------------------------------
module huffman_tree_builder_unit_tb import htb_pkg::*; ();

    localparam int MAX_LEAVES    = DEF_MAX_LEAVES;
    localparam int WEIGHT_BITS   = DEF_WEIGHT_BITS;
    localparam int RANDOM_LEAVES = 450;
    // slowest legal run stays well below this even with every run full
    localparam int CYCLE_LIMIT   = 1_000_000;
    // longer than a full build, so anything stray shows up well before this
    localparam int SETTLE_CYCLES = 4000;

    // shapes of the weights within one random run
    typedef enum int {
        PAT_ANY,        // full 16 bit range
        PAT_NARROW,     // tiny values, lots of ties
        PAT_FLAT,       // one weight for every leaf
        PAT_EXTREME,    // only zero and all ones
        PAT_WALK        // single bit set or single bit clear
    } t_weight_pat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    htb_leaf_if leaf_ch ();
    htb_node_if node_ch ();

    int chk_fails;
    int chk_pending;
    int chk_records;
    int chk_trees;
    int chk_full_trees;

    // stimulus bookkeeping
    logic [LEAF_W-1:0] run_weights[$];
    int leaves_sent = 0;
    int open_leaves = 0;    // leaves the block holds in the run that is still open
    int cycle_count = 0;
    int ready_hold  = 0;

    always #5 i_clk = ~i_clk;

    huffman_tree_builder_unit #(
        .MAX_LEAVES  (MAX_LEAVES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_leaf  (leaf_ch),
        .o_node  (node_ch)
    );

    huffman_tree_builder_unit_chk #(
        .MAX_LEAVES  (MAX_LEAVES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_leaf       (leaf_ch),
        .i_node       (node_ch),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending),
        .o_records    (chk_records),
        .o_trees      (chk_trees),
        .o_full_trees (chk_full_trees)
    );

    // record receiver: ready toggles between held levels, short stalls mostly,
    // an occasional long one, and now and then a long stretch with ready held high
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            node_ch.ready <= 1'b0;
            ready_hold    <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (node_ch.ready) begin
            node_ch.ready <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                ready_hold <= $urandom_range(15, 60);
            else
                ready_hold <= $urandom_range(0, 2);
        end else begin
            node_ch.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                ready_hold <= $urandom_range(50, 300);
            else
                ready_hold <= $urandom_range(0, 6);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d records outstanding",
                     cycle_count, chk_pending);
            $display("FAIL");
            $finish;
        end
    end

    // present one leaf word and hold it until the block takes it;
    // valid stays high so back-to-back words need no re-raise
    task automatic send_leaf(input logic [LEAF_W-1:0] w, input logic is_last);
        leaf_ch.valid       <= 1'b1;
        leaf_ch.leaf_weight <= w;
        leaf_ch.last_leaf   <= is_last;
        do @(posedge i_clk); while (!leaf_ch.ready);
        leaves_sent++;
        // a leaf that fills the store closes the run on its own
        if (is_last || open_leaves + 1 == MAX_LEAVES)
            open_leaves = 0;
        else
            open_leaves++;
    endtask

    // sender gap after a word: none most of the time, short often, long rarely
    task automatic leaf_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r >= 60) begin
            leaf_ch.valid <= 1'b0;
            if (r < 92)
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            else
                repeat ($urandom_range(10, 40)) @(posedge i_clk);
        end
    endtask

    // send the queued weights, the flag on the final one only if asked
    task automatic send_run(input logic mark_last);
        foreach (run_weights[k]) begin
            send_leaf(run_weights[k], mark_last && (k == run_weights.size() - 1));
            leaf_gap();
        end
    endtask

    // hold the sender off until every predicted record has come back
    task automatic wait_drained();
        leaf_ch.valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
    endtask

    initial begin
        int                random_base;
        int                n_run;
        int                r;
        logic              run_last;
        t_weight_pat       pat;
        logic [LEAF_W-1:0] flat_w;
        logic [LEAF_W-1:0] w;

        leaf_ch.valid       = 1'b0;
        leaf_ch.leaf_weight = '0;
        leaf_ch.last_leaf   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed runs
        // single leaf, lightest and heaviest: one record with every link none
        run_weights = '{16'd0};
        send_run(1'b1);
        run_weights = '{16'hFFFF};
        send_run(1'b1);
        // two equal leaves: lower index becomes the left child
        run_weights = '{16'd5, 16'd5};
        send_run(1'b1);
        // all zero weights, ties everywhere
        run_weights = '{16'd0, 16'd0, 16'd0};
        send_run(1'b1);
        // extremes mixed
        run_weights = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd1};
        send_run(1'b1);
        // a new node ties an older leaf, the older one must win the first pick
        run_weights = '{16'd4, 16'd3, 16'd2, 16'd1};
        send_run(1'b1);
        wait_drained();

        // random runs
        random_base = leaves_sent;
        while (leaves_sent - random_base < RANDOM_LEAVES) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                n_run = $urandom_range(1, 6);
            else if (r < 80)
                n_run = $urandom_range(7, 20);
            else if (r < 90)
                n_run = $urandom_range(21, 31);
            else
                n_run = MAX_LEAVES;
            // now and then the flag is left off and the run goes on into the next batch
            run_last = ($urandom_range(0, 19) != 0);
            pat      = t_weight_pat'($urandom_range(0, 4));
            flat_w   = ($urandom_range(0, 3) == 0) ? 16'hFFFF : LEAF_W'($urandom_range(0, 65535));

            // first two random runs: a full store of heaviest leaves with no flag,
            // so the store fill closes it at the largest sum, then a flagged full run
            if (leaves_sent == random_base) begin
                n_run    = MAX_LEAVES - open_leaves;
                run_last = 1'b0;
                pat      = PAT_FLAT;
                flat_w   = 16'hFFFF;
            end else if (leaves_sent - random_base == MAX_LEAVES) begin
                n_run    = MAX_LEAVES;
                run_last = 1'b1;
                pat      = PAT_ANY;
            end

            run_weights.delete();
            for (int k = 0; k < n_run; k++) begin
                case (pat)
                    PAT_ANY:     w = LEAF_W'($urandom_range(0, 65535));
                    PAT_NARROW:  w = LEAF_W'($urandom_range(0, 7));
                    PAT_FLAT:    w = flat_w;
                    PAT_EXTREME: w = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;
                    default: begin
                        w = 16'd1 << $urandom_range(0, 15);
                        if ($urandom_range(0, 1) != 0)
                            w = ~w;
                    end
                endcase
                run_weights.push_back(w);
            end
            send_run(run_last);

            if ($urandom_range(0, 11) == 0)
                wait_drained();
        end

        // close a run that was left open
        if (open_leaves != 0) begin
            run_weights = '{16'd1};
            send_run(1'b1);
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d leaves in %0d trees, %0d of them at full store size",
                 leaves_sent, chk_trees, chk_full_trees);
        $display("%0d node records checked field by field, %0d mismatches",
                 chk_records, chk_fails);
        if (chk_fails == 0 && chk_pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
hw/rtl/htb_pkg.sv
hw/rtl/htb_leaf_if.sv
hw/rtl/htb_node_if.sv
hw/rtl/htb_ram.sv
hw/rtl/htb_min_unit.sv
hw/rtl/huffman_tree_builder_unit.sv
tb/huffman_tree_builder_unit_chk.sv
tb/huffman_tree_builder_unit_tb.sv
